// ===== design/least_loaded_bin_assigner_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef LEAST_LOADED_BIN_ASSIGNER_MACROS_SVH
`define LEAST_LOADED_BIN_ASSIGNER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LLBA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LLBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/llba_pkg.sv =====
package llba_pkg;

    localparam int NUM_BINS   = 8;
    localparam int LOAD_WIDTH = 32;
    localparam int WEIGHT_W   = 16;
    localparam int CFG_W      = 4;
    localparam int IDX_W      = $clog2(NUM_BINS);
    localparam int CNT_W      = $clog2(NUM_BINS + 1);
    localparam int SUM_W      = LOAD_WIDTH + 1;

    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } llba_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } llba_status_t;

endpackage

// ===== design/llba_ctrl.sv =====
module llba_ctrl
    import llba_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  llba_status_t status,
    output llba_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.start = in_valid;
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.commit = status.out_free;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/llba_dp.sv =====
module llba_dp
    import llba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic [WEIGHT_W-1:0]   weight,
    input  logic                  start_batch,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [IDX_W-1:0]      bin_index,
    output logic [LOAD_WIDTH-1:0] new_load,
    output logic                  saturated,
    input  llba_cmd_t             cmd,
    output llba_status_t          status
);

    logic [CFG_W-1:0]      bins_in_use_reg;
    logic [LOAD_WIDTH-1:0] loads_reg [NUM_BINS];
    logic [WEIGHT_W-1:0]   weight_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [LOAD_WIDTH-1:0] best_load_reg;
    logic                  out_valid_reg;
    logic [IDX_W-1:0]      bin_index_reg;
    logic [LOAD_WIDTH-1:0] new_load_reg;
    logic                  saturated_reg;

    logic [CNT_W-1:0]      active;
    logic [SUM_W-1:0]      sum;
    logic                  clip;
    logic [LOAD_WIDTH-1:0] result;

    always_comb
    begin
        if (bins_in_use_reg == '0)
        begin
            active = CNT_W'(1);
        end
        else if (32'(bins_in_use_reg) > NUM_BINS)
        begin
            active = CNT_W'(NUM_BINS);
        end
        else
        begin
            active = CNT_W'(bins_in_use_reg);
        end
    end

    assign sum    = SUM_W'(best_load_reg) + SUM_W'(weight_reg);
    assign clip   = sum[SUM_W-1];
    assign result = clip ? '1 : sum[LOAD_WIDTH-1:0];

    assign status.scan_last = (idx_reg == IDX_W'(NUM_BINS - 1));
    assign status.out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bins_in_use_reg <= CFG_W'(3);
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_BINS; i++)
            begin
                loads_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wen)
            begin
                bins_in_use_reg <= cfg_wdata;
            end
            if (cmd.start && start_batch)
            begin
                for (int i = 0; i < NUM_BINS; i++)
                begin
                    loads_reg[i] <= '0;
                end
            end
            if (cmd.commit)
            begin
                loads_reg[best_idx_reg] <= result;
                out_valid_reg           <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            weight_reg    <= weight;
            idx_reg       <= IDX_W'(1);
            best_idx_reg  <= '0;
            best_load_reg <= start_batch ? '0 : loads_reg[0];
        end
        if (cmd.scan)
        begin
            idx_reg <= idx_reg + 1'b1;
            if ((CNT_W'(idx_reg) < active) && (loads_reg[idx_reg] < best_load_reg))
            begin
                best_idx_reg  <= idx_reg;
                best_load_reg <= loads_reg[idx_reg];
            end
        end
        if (cmd.commit)
        begin
            bin_index_reg <= best_idx_reg;
            new_load_reg  <= result;
            saturated_reg <= clip;
        end
    end

    assign out_valid = out_valid_reg;
    assign bin_index = bin_index_reg;
    assign new_load  = new_load_reg;
    assign saturated = saturated_reg;

endmodule

// ===== design/least_loaded_bin_assigner.sv =====
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+----------------------------------
// in       | sink      | in_valid/in_stall   | weight, start_batch
// out      | source    | out_valid/out_stall | bin_index, new_load, saturated
// cfg      | sink      | cfg_wen             | cfg_wdata (bins_in_use)
//
// Each beat is accepted, then bins 1 to 7 are walked one per cycle against the
// running minimum, and then the load is written back.
// The result sits in an output register, so the next beat is accepted while it waits.
// A write-back waits while the output register is full and stalled.
// Reset clears all bin loads and sets bins_in_use to 3.
module least_loaded_bin_assigner
    import llba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [WEIGHT_W-1:0]   weight,
    input  logic                  start_batch,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [IDX_W-1:0]      bin_index,
    output logic [LOAD_WIDTH-1:0] new_load,
    output logic                  saturated
);

    llba_cmd_t    cmd;
    llba_status_t status;

    llba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    llba_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .weight      (weight),
        .start_batch (start_batch),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .bin_index   (bin_index),
        .new_load    (new_load),
        .saturated   (saturated),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// ===== design/llba_checker.sv =====
`include "least_loaded_bin_assigner_macros.svh"

module llba_checker
    import llba_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cfg_wen,
    input logic [CFG_W-1:0]      cfg_wdata,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic [WEIGHT_W-1:0]   weight,
    input logic                  start_batch,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [IDX_W-1:0]      bin_index,
    input logic [LOAD_WIDTH-1:0] new_load,
    input logic                  saturated
);

    `LLBA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(new_load) && $stable(bin_index), "stalled output beat changed")
    `LLBA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "input accepted while an item is in progress")
    `LLBA_ASSERT_SAME(a_sat_full, clk, rst_n, out_valid && saturated, new_load == '1, "saturated result is not the maximum load")
    `LLBA_ASSERT_SAME(a_result_after_work, clk, rst_n, $rose(out_valid), $past(in_stall), "result appeared without an item in progress")

endmodule

bind least_loaded_bin_assigner llba_checker u_llba_checker (.*);
